// ===== rtl/cle_pkg.sv =====
// Shared types, command codes and status codes for the cursor list engine.
// No dependencies; every other file but cle_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package cle_pkg;

    // default sizes of the element store
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int OP_W   = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int IDX_W8 = 8;
    localparam int LEN_W  = 9;
    localparam int ST_W   = 3;

    // command codes; anything unlisted is decoded to OP_NOP
    localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 4'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 4'd2;
    localparam logic [OP_W-1:0] OP_BEGIN  = 4'd3;
    localparam logic [OP_W-1:0] OP_END    = 4'd4;
    localparam logic [OP_W-1:0] OP_PREV   = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT   = 4'd6;
    localparam logic [OP_W-1:0] OP_SETPOS = 4'd7;
    localparam logic [OP_W-1:0] OP_FIND   = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd9;
    localparam logic [OP_W-1:0] OP_NOP    = 4'd15;

    // result status
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // classified command word handed from the front to the back end
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
    } t_cmd;

endpackage

// ===== rtl/cle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cle_front.sv =====
// Front end: decodes incoming commands and holds them in a two-word queue.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_front #(
    parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [cle_pkg::OP_W-1:0]  i_command,
    input  logic [cle_pkg::VAL_W-1:0] i_value,
    input  logic [cle_pkg::POS_W-1:0] i_position,
    input  logic                      i_pop,
    output logic                      o_full,
    output logic                      o_cmd_valid,
    output cle_pkg::t_cmd             o_cmd,
    output logic [DATA_WIDTH-1:0]     o_value
);

    cle_pkg::t_cmd         w_cmd;
    logic                  w_push;
    logic                  w_pop;

    cle_pkg::t_cmd         r_q_cmd [2];
    logic [DATA_WIDTH-1:0] r_q_val [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_fill;

    always_comb begin
        w_cmd.pos = i_position;
        unique case (i_command) inside
            cle_pkg::OP_INSERT, cle_pkg::OP_APPEND, cle_pkg::OP_ERASE,
            cle_pkg::OP_BEGIN, cle_pkg::OP_END, cle_pkg::OP_PREV,
            cle_pkg::OP_NEXT, cle_pkg::OP_SETPOS, cle_pkg::OP_FIND,
            cle_pkg::OP_CLEAR: begin
                w_cmd.op = i_command;
            end
            default: begin
                w_cmd.op = cle_pkg::OP_NOP;
            end
        endcase
    end

    assign o_full      = (r_fill == 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_cmd_valid;
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_value     = r_q_val[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // only the low DATA_WIDTH bits of the value word are kept
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_cmd[r_wr_ptr] <= w_cmd;
            r_q_val[r_wr_ptr] <= DATA_WIDTH'(i_value);
        end
    end

endmodule

// ===== rtl/cle_back.sv =====
// Back end: sequencer that carries out list commands against the element RAM.
// Depends on cle_pkg; drives the ports of a cle_ram instance in the top level.
`timescale 1ns / 1ps

module cle_back #(
    parameter int DEPTH      = cle_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  cle_pkg::t_cmd            i_cmd,
    input  logic [DATA_WIDTH-1:0]    i_value,
    output logic                     o_pop,
    // element RAM
    output logic                     o_we,
    output logic [IDX_W-1:0]         o_waddr,
    output logic [DATA_WIDTH-1:0]    o_wdata,
    output logic [IDX_W-1:0]         o_raddr,
    input  logic [DATA_WIDTH-1:0]    i_rdata,
    // result
    output logic                     o_strobe,
    output logic [cle_pkg::ST_W-1:0] o_status,
    output logic [DATA_WIDTH-1:0]    o_removed,
    output logic [IDX_W-1:0]         o_found,
    output logic [IDX_W-1:0]         o_cursor,
    output logic [CNT_W-1:0]         o_count,
    output logic [DATA_WIDTH-1:0]    o_cursor_value
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_SHR   = 4'd2;
    localparam logic [3:0] S_INSW  = 4'd3;
    localparam logic [3:0] S_ERCAP = 4'd4;
    localparam logic [3:0] S_SHL   = 4'd5;
    localparam logic [3:0] S_FIND  = 4'd6;
    localparam logic [3:0] S_RDCUR = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    // control
    logic [3:0]                r_state,  n_state;
    logic [CNT_W-1:0]          r_count,  n_count;
    logic [IDX_W-1:0]          r_cursor, n_cursor;
    logic                      r_more,   n_more;
    logic                      r_wpend,  n_wpend;
    logic                      r_strobe, n_strobe;
    // payload
    logic [cle_pkg::OP_W-1:0]  r_op,     n_op;
    logic [cle_pkg::POS_W-1:0] r_pos,    n_pos;
    logic [DATA_WIDTH-1:0]     r_val,    n_val;
    logic [IDX_W-1:0]          r_ptr,    n_ptr;
    logic [IDX_W-1:0]          r_waddr,  n_waddr;
    logic [cle_pkg::ST_W-1:0]  r_status, n_status;
    logic [DATA_WIDTH-1:0]     r_removed, n_removed;
    logic [IDX_W-1:0]          r_found,  n_found;
    logic [cle_pkg::ST_W-1:0]  r_o_status, n_o_status;
    logic [DATA_WIDTH-1:0]     r_o_removed, n_o_removed;
    logic [IDX_W-1:0]          r_o_found, n_o_found;
    logic [IDX_W-1:0]          r_o_cursor, n_o_cursor;
    logic [CNT_W-1:0]          r_o_count, n_o_count;
    logic [DATA_WIDTH-1:0]     r_o_cval, n_o_cval;

    logic                      w_full;
    logic [IDX_W-1:0]          w_last;
    logic [CNT_W-1:0]          w_cur_inc;

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_last    = IDX_W'(r_count - CNT_W'(1));
    assign w_cur_inc = CNT_W'(r_cursor) + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_more      = r_more;
        n_wpend     = r_wpend;
        n_strobe    = 1'b0;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_waddr     = r_waddr;
        n_status    = r_status;
        n_removed   = r_removed;
        n_found     = r_found;
        n_o_status  = r_o_status;
        n_o_removed = r_o_removed;
        n_o_found   = r_o_found;
        n_o_cursor  = r_o_cursor;
        n_o_count   = r_o_count;
        n_o_cval    = r_o_cval;
        o_pop       = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_waddr;
        o_wdata     = i_rdata;
        o_raddr     = r_cursor;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop     = 1'b1;
                    n_op      = i_cmd.op;
                    n_pos     = i_cmd.pos;
                    n_val     = i_value;
                    n_status  = cle_pkg::ST_OK;
                    n_removed = '0;
                    n_found   = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RDCUR;
                case (r_op)
                    cle_pkg::OP_INSERT: begin
                        if (w_full) begin
                            n_status = cle_pkg::ST_FULL;
                        end else if (r_count == '0) begin
                            n_state = S_INSW;
                        end else begin
                            // move the tail up, starting from the last element
                            n_ptr   = w_last;
                            n_more  = 1'b1;
                            n_wpend = 1'b0;
                            n_state = S_SHR;
                        end
                    end
                    cle_pkg::OP_APPEND: begin
                        if (w_full) begin
                            n_status = cle_pkg::ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = IDX_W'(r_count);
                            o_wdata = r_val;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    cle_pkg::OP_ERASE: begin
                        if (r_count == '0) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else begin
                            o_raddr = r_cursor;
                            n_state = S_ERCAP;
                        end
                    end
                    cle_pkg::OP_BEGIN: begin
                        n_cursor = '0;
                    end
                    cle_pkg::OP_END: begin
                        n_cursor = (r_count == '0) ? '0 : w_last;
                    end
                    cle_pkg::OP_PREV: begin
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - IDX_W'(1);
                        end
                    end
                    cle_pkg::OP_NEXT: begin
                        if (r_count != '0 && w_cur_inc < r_count) begin
                            n_cursor = r_cursor + IDX_W'(1);
                        end
                    end
                    cle_pkg::OP_SETPOS: begin
                        if (32'(r_pos) < 32'(r_count)) begin
                            n_cursor = IDX_W'(r_pos);
                        end else begin
                            n_status = cle_pkg::ST_RANGE;
                        end
                    end
                    cle_pkg::OP_FIND: begin
                        n_status = cle_pkg::ST_NOTFOUND;
                        if (r_count != '0) begin
                            n_ptr   = '0;
                            n_more  = 1'b1;
                            n_wpend = 1'b0;
                            n_state = S_FIND;
                        end
                    end
                    cle_pkg::OP_CLEAR: begin
                        n_count  = '0;
                        n_cursor = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHR: begin
                // read at ptr, write the word read last cycle one place higher
                o_we = r_wpend;
                if (r_more) begin
                    o_raddr = r_ptr;
                    n_wpend = 1'b1;
                    n_waddr = r_ptr + IDX_W'(1);
                    if (r_ptr == r_cursor) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr - IDX_W'(1);
                    end
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_INSW;
                end
            end
            S_INSW: begin
                o_we    = 1'b1;
                o_waddr = r_cursor;
                o_wdata = r_val;
                n_count = r_count + CNT_W'(1);
                n_state = S_RDCUR;
            end
            S_ERCAP: begin
                n_removed = i_rdata;
                if (r_count != CNT_W'(1) && r_cursor == w_last) begin
                    // erased the tail: cursor steps back
                    n_cursor = r_cursor - IDX_W'(1);
                    n_count  = r_count - CNT_W'(1);
                    n_state  = S_RDCUR;
                end else if (w_cur_inc < r_count) begin
                    n_ptr   = r_cursor + IDX_W'(1);
                    n_more  = 1'b1;
                    n_wpend = 1'b0;
                    n_state = S_SHL;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RDCUR;
                end
            end
            S_SHL: begin
                o_we = r_wpend;
                if (r_more) begin
                    o_raddr = r_ptr;
                    n_wpend = 1'b1;
                    n_waddr = r_ptr - IDX_W'(1);
                    if (r_ptr == w_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr + IDX_W'(1);
                    end
                end else begin
                    n_wpend = 1'b0;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RDCUR;
                end
            end
            S_FIND: begin
                // r_waddr tags the index whose word is on the read port
                if (r_wpend && i_rdata == r_val) begin
                    n_found  = r_waddr;
                    n_status = cle_pkg::ST_OK;
                    n_wpend  = 1'b0;
                    n_state  = S_RDCUR;
                end else if (r_more) begin
                    o_raddr = r_ptr;
                    n_wpend = 1'b1;
                    n_waddr = r_ptr;
                    if (r_ptr == w_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr + IDX_W'(1);
                    end
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_RDCUR;
                end
            end
            S_RDCUR: begin
                o_raddr = r_cursor;
                n_state = S_RESP;
            end
            S_RESP: begin
                n_strobe    = 1'b1;
                n_o_status  = r_status;
                n_o_removed = r_removed;
                n_o_found   = r_found;
                n_o_cursor  = r_cursor;
                n_o_count   = r_count;
                n_o_cval    = (r_count == '0) ? '0 : i_rdata;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_more   <= 1'b0;
            r_wpend  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_more   <= n_more;
            r_wpend  <= n_wpend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_waddr     <= n_waddr;
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_found     <= n_found;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_found   <= n_o_found;
        r_o_cursor  <= n_o_cursor;
        r_o_count   <= n_o_count;
        r_o_cval    <= n_o_cval;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_o_status;
    assign o_removed      = r_o_removed;
    assign o_found        = r_o_found;
    assign o_cursor       = r_o_cursor;
    assign o_count        = r_o_count;
    assign o_cursor_value = r_o_cval;

endmodule

// ===== rtl/cursor_list_engine_core.sv =====
// Cursor list engine. The sequencer takes one command at a time from the queue and
// returns one result word for it; moves, append and clear need no element shifts, insert
// and erase also shift the elements behind the cursor, and find compares elements in
// order until a match (none on an empty list).
// Two commands queue ahead of the sequencer; busy is high while the queue is full.
// Reset empties the command queue and clears length and cursor; store contents stay undefined until written.
`timescale 1ns / 1ps

module cursor_list_engine_core #(
    parameter int DEPTH      = cle_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cle_pkg::OP_W-1:0]   i_command,
    input  logic [cle_pkg::VAL_W-1:0]  i_value,
    input  logic [cle_pkg::POS_W-1:0]  i_position,
    output logic                       o_strobe,
    output logic [cle_pkg::ST_W-1:0]   o_status,
    output logic [cle_pkg::VAL_W-1:0]  o_removed_value,
    output logic [cle_pkg::IDX_W8-1:0] o_found_index,
    output logic [cle_pkg::IDX_W8-1:0] o_cursor_pos,
    output logic [cle_pkg::LEN_W-1:0]  o_list_length,
    output logic [cle_pkg::VAL_W-1:0]  o_cursor_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  w_full;
    logic                  w_cmd_valid;
    cle_pkg::t_cmd         w_cmd;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_pop;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [IDX_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [DATA_WIDTH-1:0] w_removed;
    logic [IDX_W-1:0]      w_found;
    logic [IDX_W-1:0]      w_cursor;
    logic [CNT_W-1:0]      w_count;
    logic [DATA_WIDTH-1:0] w_cval;

    assign busy = w_full;

    cle_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (start),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .o_value     (w_value)
    );

    cle_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .i_value        (w_value),
        .o_pop          (w_pop),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_removed      (w_removed),
        .o_found        (w_found),
        .o_cursor       (w_cursor),
        .o_count        (w_count),
        .o_cursor_value (w_cval)
    );

    cle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // fit internal widths to the fixed port widths
    assign o_removed_value = cle_pkg::VAL_W'(w_removed);
    assign o_found_index   = cle_pkg::IDX_W8'(w_found);
    assign o_cursor_pos    = cle_pkg::IDX_W8'(w_cursor);
    assign o_list_length   = cle_pkg::LEN_W'(w_count);
    assign o_cursor_value  = cle_pkg::VAL_W'(w_cval);

endmodule
